// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define TLCD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TLCD_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tlcd_pkg.sv =====
`timescale 1ns / 1ps

package tlcd_pkg;

	localparam int DIGITS      = 4;
	localparam int DIGIT_IDX_W = $clog2(DIGITS);
	localparam int TIME_W      = 7;

	typedef enum logic [1:0] {
		LIGHT_RED   = 2'd0,
		LIGHT_GREEN = 2'd1,
		LIGHT_AMBER = 2'd2
	} light_t;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_SCAN  = 2'd2;

	localparam logic [1:0] REG_RED   = 2'd0;
	localparam logic [1:0] REG_GREEN = 2'd1;
	localparam logic [1:0] REG_AMBER = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] red;
		logic [TIME_W-1:0] green;
		logic [TIME_W-1:0] amber;
	} cfg_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

	localparam logic [6:0] SEG_TABLE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	// Tens by multiply with 205/2048, exact for values below 1029.
	function automatic digits_t split_digits(input logic [6:0] v);
		logic [14:0] prod;
		logic [6:0]  tens10;
		digits_t     d;
		prod    = 15'(v) * 15'd205;
		d.tens  = prod[14:11];
		tens10  = 7'(d.tens) * 7'd10;
		d.units = 4'(v - tens10);
		return d;
	endfunction

endpackage

// ===== rtl/core/tlcd_light_next.sv =====
`timescale 1ns / 1ps

module tlcd_light_next (
	input  tlcd_pkg::light_t                  light,
	input  logic [tlcd_pkg::TIME_W-1:0]       count,
	input  tlcd_pkg::cfg_t                    times,
	output tlcd_pkg::light_t                  next_light,
	output logic [tlcd_pkg::TIME_W-1:0]       next_count
);
	import tlcd_pkg::*;

	// Step the phase when the countdown runs out, otherwise count down.
	always_comb begin
		next_light = light;
		next_count = count - TIME_W'(1);
		if (count <= TIME_W'(1)) begin
			case (light)
				LIGHT_RED: begin
					next_light = LIGHT_GREEN;
					next_count = times.green;
				end
				LIGHT_GREEN: begin
					next_light = LIGHT_AMBER;
					next_count = times.amber;
				end
				LIGHT_AMBER: begin
					next_light = LIGHT_RED;
					next_count = times.red;
				end
				default: begin
					next_count = '0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/traffic_light_with_countdown_display_unit.sv =====
`timescale 1ns / 1ps
// A request is registered in the input stage, and its result is then registered onto m_tdata.
// Throughput: one request per cycle while m_tready does not stall the result register.
// A stalled result register holds while the input stage still takes one request.
// Reset (arst_n low): horizontal red, vertical green, counters and digits zero,
// scan on digit 0, segments dark, durations red 5 / green 3 / amber 2.
`include "assert_macros.svh"

module traffic_light_with_countdown_display_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // [3:0] mode, [10:4] value, rest zero
	input  logic [1:0]                   s_tuser,   // [1:0] cmd
	// result channel
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // [5:0] lamps, [12:6] segments,
	                                                // [16:13] digit_enable, rest zero
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [tlcd_pkg::TIME_W-1:0]  cfg_data
);
	import tlcd_pkg::*;

	// Lamp one-hot for one light: bit0 red, bit1 amber, bit2 green.
	function automatic logic [2:0] lamp_bits(input light_t l);
		logic [2:0] b;
		unique case (l)
			LIGHT_RED:   b = 3'b001;
			LIGHT_AMBER: b = 3'b010;
			LIGHT_GREEN: b = 3'b100;
			default:     b = 3'b000;
		endcase
		return b;
	endfunction

	// ---------------------------------------------------------------
	// Configuration: always ready, write the addressed duration.
	// ---------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red   <= TIME_W'(5);
			cfg_q.green <= TIME_W'(3);
			cfg_q.amber <= TIME_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RED:   cfg_q.red   <= cfg_data;
				REG_GREEN: cfg_q.green <= cfg_data;
				REG_AMBER: cfg_q.amber <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake: the input stage moves whenever it is empty or the result
	// register is empty or being drained this cycle.
	// ---------------------------------------------------------------
	logic       s1_valid_q;
	logic [1:0] cmd_s1;
	logic [3:0] mode_s1;
	logic [6:0] value_s1;
	logic       m_valid_q;
	logic [23:0] m_data_q;
	logic       out_adv;
	logic       fire_s1;

	assign out_adv  = !m_valid_q || m_tready;
	assign s_tready = !s1_valid_q || out_adv;
	assign fire_s1  = s1_valid_q && out_adv;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	// Payload of the input stage: no reset needed.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			mode_s1  <= s_tdata[3:0];
			value_s1 <= s_tdata[10:4];
		end
	end

	// ---------------------------------------------------------------
	// Controller state.
	// ---------------------------------------------------------------
	light_t                  h_light_q, v_light_q;
	logic [TIME_W-1:0]       h_count_q, v_count_q;
	logic [3:0]              digit_store_q [DIGITS];
	logic [DIGIT_IDX_W-1:0]  scan_q;
	logic [6:0]              seg_q;

	light_t                  h_light_d, v_light_d;
	logic [TIME_W-1:0]       h_count_d, v_count_d;
	logic [3:0]              digit_store_d [DIGITS];
	logic [DIGIT_IDX_W-1:0]  scan_d;
	logic [6:0]              seg_d;

	// Tick candidates for both lights.
	light_t                  h_light_tick, v_light_tick;
	logic [TIME_W-1:0]       h_count_tick, v_count_tick;

	tlcd_light_next u_h_next (
		.light      (h_light_q),
		.count      (h_count_q),
		.times      (cfg_q),
		.next_light (h_light_tick),
		.next_count (h_count_tick)
	);

	tlcd_light_next u_v_next (
		.light      (v_light_q),
		.count      (v_count_q),
		.times      (cfg_q),
		.next_light (v_light_tick),
		.next_count (v_count_tick)
	);

	digits_t                 h_digits, v_digits, val_digits;
	logic [DIGIT_IDX_W-1:0]  scan_inc;
	logic [3:0]              scan_digit;

	assign h_digits   = split_digits(h_count_tick);
	assign v_digits   = split_digits(v_count_tick);
	assign val_digits = split_digits(value_s1);
	assign scan_inc   = scan_q + DIGIT_IDX_W'(1);

	// Digit picked by a scan: countdown store in mode 1, else value and mode.
	always_comb begin
		if (mode_s1 == 4'd1) begin
			scan_digit = digit_store_q[scan_inc];
		end else begin
			unique case (scan_inc)
				2'd0: scan_digit = val_digits.tens;
				2'd1: scan_digit = val_digits.units;
				2'd2: scan_digit = 4'd0;
				2'd3: scan_digit = mode_s1;
			endcase
		end
	end

	// Next state for the request in the input stage.
	always_comb begin
		h_light_d     = h_light_q;
		v_light_d     = v_light_q;
		h_count_d     = h_count_q;
		v_count_d     = v_count_q;
		digit_store_d = digit_store_q;
		scan_d        = scan_q;
		seg_d         = seg_q;
		unique case (cmd_s1)
			CMD_START: begin
				// Restore phases and load both counters.
				h_light_d = LIGHT_RED;
				v_light_d = LIGHT_GREEN;
				h_count_d = cfg_q.red;
				v_count_d = cfg_q.green;
			end
			CMD_TICK: begin
				h_light_d        = h_light_tick;
				v_light_d        = v_light_tick;
				h_count_d        = h_count_tick;
				v_count_d        = v_count_tick;
				digit_store_d[0] = h_digits.tens;
				digit_store_d[1] = h_digits.units;
				digit_store_d[2] = v_digits.tens;
				digit_store_d[3] = v_digits.units;
			end
			CMD_SCAN: begin
				scan_d = scan_inc;
				// Hold the segments on a digit above nine.
				if (scan_digit <= 4'd9) begin
					seg_d = SEG_TABLE[scan_digit];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_light_q     <= LIGHT_RED;
			v_light_q     <= LIGHT_GREEN;
			h_count_q     <= '0;
			v_count_q     <= '0;
			digit_store_q <= '{default: '0};
			scan_q        <= '0;
			seg_q         <= '0;
		end else if (fire_s1) begin
			h_light_q     <= h_light_d;
			v_light_q     <= v_light_d;
			h_count_q     <= h_count_d;
			v_count_q     <= v_count_d;
			digit_store_q <= digit_store_d;
			scan_q        <= scan_d;
			seg_q         <= seg_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register: report the state left by the request.
	// ---------------------------------------------------------------
	logic [DIGITS-1:0] enable_d;

	assign enable_d = DIGITS'(1) << scan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			m_data_q <= {7'b0, enable_d, seg_d, lamp_bits(v_light_d), lamp_bits(h_light_d)};
		end
	end

	// ---------------------------------------------------------------
	// Checks.
	// ---------------------------------------------------------------
	`TLCD_ASSERT(a_enable_onehot, clk, arst_n, m_valid_q |-> $onehot(m_data_q[16:13]), "digit enable not one-hot")
	`TLCD_ASSERT(a_start_phases, clk, arst_n, fire_s1 && cmd_s1 == CMD_START |=> h_light_q == LIGHT_RED && v_light_q == LIGHT_GREEN, "start did not restore phases")
	`TLCD_ASSERT(a_scan_step, clk, arst_n, fire_s1 && cmd_s1 == CMD_SCAN |=> scan_q == $past(scan_q) + DIGIT_IDX_W'(1), "scan index did not advance by one")
	`TLCD_ASSERT(a_seg_hold, clk, arst_n, fire_s1 && cmd_s1 != CMD_SCAN |=> $stable(seg_q), "segments changed outside a scan")
	`TLCD_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_valid_q |-> s_tready, "input stalled with empty result register")

endmodule
